// File: design/led_frame_serializer_unit_defines.svh
// Assertion macros shared by the LED frame serialiser checker.
// No dependencies.
`ifndef LED_FRAME_SERIALIZER_UNIT_DEFINES_SVH
`define LED_FRAME_SERIALIZER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define LFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define LFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lfs_pkg.sv
// Types and constants for the LED frame serialiser.
// No dependencies.
`timescale 1ns / 1ps

package lfs_pkg;

    localparam logic [5:0] WORD_BITS     = 6'd32;
    localparam logic [7:0] END_BITS_CAP  = 8'd128;
    localparam logic [7:0] BRIGHT_RESET  = 8'hFF;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_LED   = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // everything the beat sequencer needs for one LED
    typedef struct packed {
        logic [31:0] led_word;
        logic        has_start;
        logic        is_last;
        logic [1:0]  n_full;     // full 32-bit end words before the final one
        logic [5:0]  last_bits;  // bits in the final end word
    } t_plan;

endpackage

// File: design/lfs_plan.sv
// Frame state, brightness register and per-LED plan of the output beats.
// Depends on lfs_pkg.
`timescale 1ns / 1ps

module lfs_plan import lfs_pkg::*; #(
    parameter int MAX_LEDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_brightness_byte,
    input  logic [7:0]  i_led_blue,
    input  logic [7:0]  i_led_green,
    input  logic [7:0]  i_led_red,
    input  logic        i_last_led,
    input  logic        i_take,
    output t_plan       o_plan
);

    localparam int LW = $clog2(MAX_LEDS + 1);
    localparam int CW = (LW + 1 > 8) ? LW + 1 : 8;

    logic [7:0]    r_bright;
    logic          r_in_frame;
    logic [LW-1:0] r_leds;

    logic [LW-1:0] leds_cur;
    logic [LW-1:0] leds_next;
    logic [LW:0]   bits_raw;
    logic [CW-1:0] bits_ext;
    logic [7:0]    bits;
    logic [7:0]    bits_m1;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        leds_cur  = r_in_frame ? r_leds : '0;
        leds_next = (leds_cur < LW'(MAX_LEDS)) ? leds_cur + LW'(1) : leds_cur;
        bits_raw  = ({1'b0, leds_next} + (LW+1)'(1)) >> 1;
        bits_ext  = CW'(bits_raw);
        bits      = (bits_ext > CW'(END_BITS_CAP)) ? END_BITS_CAP : bits_ext[7:0];
        bits_m1   = bits - 8'd1;
    end

    always_comb begin
        o_plan.led_word  = {r_bright, i_led_blue, i_led_green, i_led_red};
        o_plan.has_start = !r_in_frame;
        o_plan.is_last   = i_last_led;
        o_plan.n_full    = bits_m1[6:5];
        o_plan.last_bits = {1'b0, bits_m1[4:0]} + 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright   <= BRIGHT_RESET;
            r_in_frame <= 1'b0;
            r_leds     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_bright <= i_brightness_byte;
            end
            if (i_take) begin
                r_in_frame <= !i_last_led;
                r_leds     <= i_last_led ? '0 : leds_next;
            end
        end
    end

endmodule

// File: design/lfs_emit.sv
// Hold register for one planned LED, beat sequencer and output register.
// Depends on lfs_pkg.
`timescale 1ns / 1ps

module lfs_emit import lfs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    output logic        o_take,
    input  t_plan       i_plan,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_frame_word,
    output logic [5:0]  o_bit_count,
    output logic [1:0]  o_word_kind,
    output logic        o_frame_end
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_LED   = 2'd1;
    localparam logic [1:0] PH_END   = 2'd2;

    logic        r_hold_valid;
    t_plan       r_plan;
    logic [1:0]  r_phase;
    logic [1:0]  n_phase;
    logic [1:0]  r_full_left;

    logic        r_out_valid;
    logic [31:0] r_word;
    logic [5:0]  r_bits;
    logic [1:0]  r_kind;
    logic        r_end;

    logic        out_free;
    logic        advance;
    logic        beat_done;
    logic [31:0] beat_word;
    logic [5:0]  beat_bits;
    logic [1:0]  beat_kind;
    logic        beat_end;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_hold_valid && out_free;
    assign o_in_stall = r_hold_valid && !(advance && beat_done);
    assign o_take     = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (r_phase)
            PH_START: begin
                beat_word = '0;
                beat_bits = WORD_BITS;
                beat_kind = KIND_START;
                beat_end  = 1'b0;
                beat_done = 1'b0;
                n_phase   = PH_LED;
            end
            PH_LED: begin
                beat_word = r_plan.led_word;
                beat_bits = WORD_BITS;
                beat_kind = KIND_LED;
                beat_end  = 1'b0;
                beat_done = !r_plan.is_last;
                n_phase   = PH_END;
            end
            PH_END: begin
                beat_word = '0;
                beat_bits = (r_full_left != 2'd0) ? WORD_BITS : r_plan.last_bits;
                beat_kind = KIND_END;
                beat_end  = (r_full_left == 2'd0);
                beat_done = (r_full_left == 2'd0);
                n_phase   = PH_END;
            end
            default: begin
                beat_word = '0;
                beat_bits = WORD_BITS;
                beat_kind = KIND_START;
                beat_end  = 1'b0;
                beat_done = 1'b1;
                n_phase   = PH_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_phase      <= PH_START;
            r_full_left  <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_take) begin
                r_hold_valid <= 1'b1;
                r_phase      <= i_plan.has_start ? PH_START : PH_LED;
                r_full_left  <= i_plan.n_full;
            end else if (advance) begin
                if (beat_done) begin
                    r_hold_valid <= 1'b0;
                end
                r_phase <= n_phase;
                if (r_phase == PH_END) begin
                    r_full_left <= r_full_left - 2'd1;
                end
            end
            if (out_free) begin
                r_out_valid <= advance;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_plan <= i_plan;
        end
        if (advance) begin
            r_word <= beat_word;
            r_bits <= beat_bits;
            r_kind <= beat_kind;
            r_end  <= beat_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_word = r_word;
    assign o_bit_count  = r_bits;
    assign o_word_kind  = r_kind;
    assign o_frame_end  = r_end;

endmodule

// File: design/led_frame_serializer_unit.sv
// LED strip frame serialiser: one LED colour beat in, one or more 32-bit frame
// words out (start word, LED word, end-frame words).
// Usage:
//   Input channel i_in_valid / o_in_stall carries blue, green, red and a last-LED
//   flag. Output channel o_out_valid / i_out_stall carries frame_word, bit_count,
//   word_kind and frame_end; words are shifted MSB first downstream.
//   Config channel i_cfg_valid / o_cfg_ready writes the brightness byte (reset
//   0xFF); ready is always high, write only while idle.
//   Each LED gives 1 to 5 output beats: a start word when it opens a frame,
//   its LED word, and after the last LED ceil(n/2) zero bits of end frame in
//   words of up to 32 bits, n capped at MAX_LEDS.
//   Input beats pass the hold register, then the output register.
//   Throughput: one output beat per cycle, set by the single output register,
//   unless stalled; a mid-frame LED is one beat, so an LED is taken per cycle.
//   A hold register and the output register part the two sides, so the next
//   LED is taken while the last word of the previous one waits.
//   Stall: a stalled output word holds; once the hold register is full the
//   input is stalled as well. Reset clears the frame state and empties both.
// Depends on lfs_pkg, lfs_plan, lfs_emit.
`timescale 1ns / 1ps

module led_frame_serializer_unit import lfs_pkg::*; #(
    parameter int MAX_LEDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_brightness_byte,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_led_blue,
    input  logic [7:0]  i_led_green,
    input  logic [7:0]  i_led_red,
    input  logic        i_last_led,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_frame_word,
    output logic [5:0]  o_bit_count,
    output logic [1:0]  o_word_kind,
    output logic        o_frame_end
);

    t_plan plan;
    logic  take;

    lfs_plan #(
        .MAX_LEDS(MAX_LEDS)
    ) u_plan (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_brightness_byte (i_brightness_byte),
        .i_led_blue        (i_led_blue),
        .i_led_green       (i_led_green),
        .i_led_red         (i_led_red),
        .i_last_led        (i_last_led),
        .i_take            (take),
        .o_plan            (plan)
    );

    lfs_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_take       (take),
        .i_plan       (plan),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_frame_word (o_frame_word),
        .o_bit_count  (o_bit_count),
        .o_word_kind  (o_word_kind),
        .o_frame_end  (o_frame_end)
    );

endmodule

// File: design/lfs_checker.sv
// Port-level checks for the LED frame serialiser, bound to the top level.
// Depends on lfs_pkg and led_frame_serializer_unit_defines.svh.
`timescale 1ns / 1ps
`include "led_frame_serializer_unit_defines.svh"

module lfs_checker import lfs_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_frame_word,
    input logic [5:0]  o_bit_count,
    input logic [1:0]  o_word_kind,
    input logic        o_frame_end
);

    `LFS_ASSERT_NOW(a_end_kind, i_clk, i_rst_n, o_out_valid && o_frame_end,
        o_word_kind == KIND_END, "frame end on a word that is not end frame")

    `LFS_ASSERT_NOW(a_short_final, i_clk, i_rst_n,
        o_out_valid && (o_bit_count != WORD_BITS),
        o_frame_end && (o_word_kind == KIND_END), "short word before end of frame")

    `LFS_ASSERT_NOW(a_zero_fill, i_clk, i_rst_n,
        o_out_valid && (o_word_kind != KIND_LED),
        o_frame_word == 32'd0, "start or end word not all zero")

    `LFS_ASSERT_NEXT(a_led_after_start, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && (o_word_kind == KIND_START),
        o_out_valid && (o_word_kind == KIND_LED), "start word not followed by LED word")

    `LFS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_frame_word) && $stable(o_bit_count),
        "stalled output beat changed")

endmodule

bind led_frame_serializer_unit lfs_checker u_lfs_checker (.*);

// File: tb/led_frame_serializer_unit_tb.sv
// Self-checking testbench for led_frame_serializer_unit: directed table, then random
// frames over several brightness settings, with random idling on both channels.
// Depends on lfs_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module led_frame_serializer_unit_tb;
    import lfs_pkg::*;

    localparam int LED_LIMIT = 256;
    localparam int RND_ITEMS = 380;
    localparam int CALM_FROM = 330;
    localparam int N_DIR     = 13;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
    } led_beat_t;

    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  bits;
        logic [1:0]  kind;
        logic        fin;
    } word_beat_t;

    typedef struct packed {
        logic [7:0]  bright;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        last;
        logic        known;
        logic [31:0] word;
    } dir_row_t;

    // brightness, blue, green, red, last, typed-in, LED word
    localparam dir_row_t DIR_TABLE [N_DIR] = '{
        {8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 32'hFF00_0000},
        {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
        {8'hFF, 8'h01, 8'h02, 8'h03, 1'b0, 1'b0, 32'h0},
        {8'hFF, 8'h80, 8'h40, 8'h20, 1'b0, 1'b0, 32'h0},
        {8'hFF, 8'hAA, 8'h55, 8'hAA, 1'b1, 1'b1, 32'hFFAA_55AA},
        {8'h00, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 32'h0},
        {8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1, 32'h00FF_00FF},
        {8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 32'h0000_FF00},
        {8'h00, 8'h7F, 8'h7F, 8'h7F, 1'b1, 1'b0, 32'h0},
        {8'h80, 8'h55, 8'hAA, 8'h55, 1'b1, 1'b1, 32'h8055_AA55},
        {8'h01, 8'hFE, 8'hDC, 8'hBA, 1'b0, 1'b0, 32'h0},
        {8'h01, 8'h01, 8'h01, 8'h01, 1'b1, 1'b1, 32'h0101_0101},
        {8'hE5, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 32'hE500_00FF}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_brightness_byte;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_led_blue;
    logic [7:0]  i_led_green;
    logic [7:0]  i_led_red;
    logic        i_last_led;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_frame_word;
    logic [5:0]  o_bit_count;
    logic [1:0]  o_word_kind;
    logic        o_frame_end;

    logic        calm = 1'b0;
    int          bad_words = 0;
    int          stall_left = 0;
    logic        stall_on = 1'b0;

    word_beat_t  pending_words [$];
    logic [7:0]  cur_bright = BRIGHT_RESET;
    logic        frm_open = 1'b0;
    int unsigned frm_leds = 0;

    led_frame_serializer_unit #(
        .MAX_LEDS(LED_LIMIT)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_brightness_byte(i_brightness_byte),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_led_blue(i_led_blue),
        .i_led_green(i_led_green),
        .i_led_red(i_led_red),
        .i_last_led(i_last_led),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_frame_word(o_frame_word),
        .o_bit_count(o_bit_count),
        .o_word_kind(o_word_kind),
        .o_frame_end(o_frame_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // frame words that one LED beat gives: start word, LED word, end-frame words
    function automatic void predict_led_words(input led_beat_t led, input logic known,
                                              input logic [31:0] typed_word);
        int unsigned nbits;
        logic [31:0] led_word;
        if (!frm_open) begin
            pending_words.push_back({32'h0, WORD_BITS, KIND_START, 1'b0});
            frm_open = 1'b1;
            frm_leds = 0;
        end
        led_word = known ? typed_word : {cur_bright, led.blue, led.green, led.red};
        pending_words.push_back({led_word, WORD_BITS, KIND_LED, 1'b0});
        if (frm_leds < LED_LIMIT)
            frm_leds++;
        if (led.last) begin
            nbits = (frm_leds + 1) / 2;
            if (nbits == 0)
                nbits = 1;
            if (nbits > END_BITS_CAP)
                nbits = END_BITS_CAP;
            while (nbits > 32) begin
                pending_words.push_back({32'h0, WORD_BITS, KIND_END, 1'b0});
                nbits -= 32;
            end
            pending_words.push_back({32'h0, 6'(nbits), KIND_END, 1'b1});
            frm_open = 1'b0;
            frm_leds = 0;
        end
    endfunction

    task automatic send_led(input led_beat_t led, input logic known,
                            input logic [31:0] typed_word);
        i_in_valid  <= 1'b1;
        i_led_blue  <= led.blue;
        i_led_green <= led.green;
        i_led_red   <= led.red;
        i_last_led  <= led.last;
        do @(posedge i_clk); while (o_in_stall);
        predict_led_words(led, known, typed_word);
    endtask

    task automatic idle_gap();
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained(input int hold);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (hold) @(posedge i_clk);
    endtask

    task automatic write_brightness(input logic [7:0] val);
        wait_drained(4);
        i_cfg_valid       <= 1'b1;
        i_brightness_byte <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_bright = val;
    endtask

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_on   = ($urandom_range(0, 3) == 0);
            stall_left = stall_on ? $urandom_range(1, 9) : $urandom_range(1, 12);
        end
        stall_left--;
        i_out_stall <= stall_on && !calm;
    end

    always @(posedge i_clk) begin : word_check
        word_beat_t got;
        word_beat_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_frame_word, o_bit_count, o_word_kind, o_frame_end};
            if (pending_words.size() == 0) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected beat: word=%h bits=%0d kind=%0d end=%b",
                             got.word, got.bits, got.kind, got.fin);
            end else begin
                want = pending_words.pop_front();
                if (got.word !== want.word || got.bits !== want.bits ||
                    got.kind !== want.kind || got.fin !== want.fin) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("mismatch: want %h/%0d/%0d/%b got %h/%0d/%0d/%b",
                                 want.word, want.bits, want.kind, want.fin,
                                 got.word, got.bits, got.kind, got.fin);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stim
        dir_row_t  row;
        led_beat_t led;
        int        rnd_items;
        int        frames;
        int        len;
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_brightness_byte = 8'h00;
        i_in_valid        = 1'b0;
        i_led_blue        = 8'h00;
        i_led_green       = 8'h00;
        i_led_red         = 8'h00;
        i_last_led        = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            row = DIR_TABLE[i];
            if (row.bright != cur_bright)
                write_brightness(row.bright);
            led = {row.blue, row.green, row.red, row.last};
            idle_gap();
            send_led(led, row.known, row.word);
        end

        // one frame past the LED limit first, then mostly short frames with a
        // few long enough for multi-word end frames
        rnd_items = 0;
        frames    = 0;
        write_brightness(8'h00);
        while (rnd_items < RND_ITEMS) begin
            if (frames == 0) begin
                write_brightness(8'hFF);
                len = LED_LIMIT + 14;
            end else begin
                case ($urandom_range(0, 11))
                    0: len = $urandom_range(63, 66);
                    1: len = $urandom_range(127, 130);
                    default: len = $urandom_range(1, 8);
                endcase
                if (len > RND_ITEMS - rnd_items)
                    len = RND_ITEMS - rnd_items;
            end
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 39) == 0)
                    write_brightness(8'($urandom_range(0, 255)));
                led.blue  = 8'($urandom);
                led.green = 8'($urandom);
                led.red   = 8'($urandom);
                led.last  = (k == len - 1);
                if (rnd_items >= CALM_FROM)
                    calm <= 1'b1;
                idle_gap();
                send_led(led, 1'b0, 32'h0);
                rnd_items++;
            end
            frames++;
        end

        wait_drained(10);
        if (bad_words == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
